### sv/tcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_pkg
// shared constants and types of the timed command dispatcher
// ----------------------------------------------------------------------------
package tcd_pkg;

  localparam int NUM_QUEUES  = 16;
  localparam int QUEUE_DEPTH = 64;
  localparam int QIDX_W      = $clog2(NUM_QUEUES);
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = SLOT_W + 1;
  localparam int ADDR_W      = QIDX_W + SLOT_W;
  localparam int INFO_W      = 33;
  localparam int ENTRY_W     = 32 + INFO_W;

  localparam logic [7:0] FREE_OWNER = 8'hFE;

  localparam logic [1:0] CFG_QUEUES  = 2'd0;
  localparam logic [1:0] CFG_TOTAL   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    FUNC_LOAD  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_STOP  = 3'd2,
    FUNC_TICK  = 3'd3,
    FUNC_POLL  = 3'd4,
    FUNC_REPLY = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    KIND_ACK       = 3'd0,
    KIND_DISPATCH  = 3'd1,
    KIND_CONFIRMED = 3'd2,
    KIND_MISMATCH  = 3'd3,
    KIND_TIMEOUT   = 3'd4,
    KIND_NOFREE    = 3'd5,
    KIND_FULL      = 3'd6
  } kind_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

### sv/tcd_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_entry_mem
// command entry store: due time and command info, one write and one read port
// ----------------------------------------------------------------------------
module tcd_entry_mem (
  input  logic                        clk,
  input  tcd_pkg::mem_req_t           req,
  output logic [tcd_pkg::ENTRY_W-1:0] rd_data
);

  logic [tcd_pkg::ENTRY_W-1:0] mem [tcd_pkg::NUM_QUEUES*tcd_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

### sv/timed_command_dispatcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_command_dispatcher_top
// per-device command queues with timed dispatch and reply tracking
// ----------------------------------------------------------------------------
// One word is taken at a time and answered with exactly one result word. Start,
// stop, tick and a poll that finds nothing to do go from S_EXEC straight to
// S_DONE. A load walks the queue owner table with one compare per cycle, then
// stores the command in S_LWR, or answers that no queue is free. A poll that
// scans for a due head reads the entry memory and compares the due time for
// each non-empty queue, in S_PRD and S_PCMP. A timeout, confirm or mismatch
// reads the head entry once, in S_HRD and S_HUSE. The entry memory read port
// is registered. The input is taken again once the result sits in the output
// register; the next result waits in S_DONE while the output is stalled.
module timed_command_dispatcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_dev_address,
  input  logic [31:0] in_due_time,
  input  logic [7:0]  in_cmd_class,
  input  logic [7:0]  in_cmd_instruction,
  input  logic        in_bus_select,
  input  logic [15:0] in_param_tag,
  input  logic [7:0]  in_reply_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_address,
  output logic [7:0]  out_class,
  output logic [7:0]  out_instruction,
  output logic        out_bus,
  output logic [15:0] out_tag,
  output logic        out_run_active,
  output logic [15:0] out_confirmed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QW = tcd_pkg::QIDX_W;
  localparam int SW = tcd_pkg::SLOT_W;
  localparam int FW = tcd_pkg::FILL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_LSRCH, S_LWR, S_PRD, S_PCMP, S_HRD, S_HUSE, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [4:0]  cfg_queues_r;
  logic [15:0] cfg_total_r;
  logic [15:0] cfg_timeout_r;

  // captured word
  tcd_pkg::func_t func_r;
  logic [7:0]  addr_r;
  logic [31:0] due_r;
  logic [7:0]  class_r;
  logic [7:0]  instr_r;
  logic        bus_r;
  logic [15:0] tag_r;
  logic [7:0]  reply_r;

  // block state
  logic [31:0] time_r;
  logic        running_r;
  logic        awaiting_r;
  logic [15:0] wait_r;
  logic [15:0] done_r;
  logic [QW-1:0] scan_r;
  logic [7:0]    owner_r [tcd_pkg::NUM_QUEUES];
  logic [SW-1:0] head_r  [tcd_pkg::NUM_QUEUES];
  logic [SW-1:0] tail_r  [tcd_pkg::NUM_QUEUES];
  logic [FW-1:0] fill_r  [tcd_pkg::NUM_QUEUES];

  // sequencer working registers
  logic [QW-1:0] cur_q_r;
  logic [QW-1:0] cnt_r;
  logic          free_found_r;
  logic [QW-1:0] free_q_r;

  // pending result
  tcd_pkg::kind_t res_kind_r;
  logic           res_head_r;
  logic [7:0]     res_addr_r;

  tcd_pkg::mem_req_t           mem_req;
  logic [tcd_pkg::ENTRY_W-1:0] rd_data;
  logic [31:0]                 rd_due;
  logic [tcd_pkg::INFO_W-1:0]  rd_info;

  logic [QW:0]   nq;
  logic          last_cnt;
  logic [QW-1:0] cur_next;
  logic [QW-1:0] scan_next;
  logic [15:0]   wait_inc;
  logic [15:0]   lim;
  logic [15:0]   done_inc;

  assign rd_due  = rd_data[tcd_pkg::ENTRY_W-1:tcd_pkg::INFO_W];
  assign rd_info = rd_data[tcd_pkg::INFO_W-1:0];

  always_comb begin
    if (cfg_queues_r == 5'd0) begin
      nq = (QW+1)'(1);
    end else if ({{(QW+1){1'b0}}, cfg_queues_r} > (QW+6)'(tcd_pkg::NUM_QUEUES)) begin
      nq = (QW+1)'(tcd_pkg::NUM_QUEUES);
    end else begin
      nq = (QW+1)'(cfg_queues_r);
    end
  end

  assign last_cnt  = ({1'b0, cnt_r} + (QW+1)'(1)) >= nq;
  assign cur_next  = (({1'b0, cur_q_r} + (QW+1)'(1)) >= nq) ? '0 : cur_q_r + QW'(1);
  assign scan_next = (({1'b0, scan_r} + (QW+1)'(1)) >= nq) ? '0 : scan_r + QW'(1);
  assign wait_inc  = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;
  assign lim       = (cfg_timeout_r == 16'd0) ? 16'd1 : cfg_timeout_r;
  assign done_inc  = (done_r == 16'hFFFF) ? done_r : done_r + 16'd1;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // entry memory requests
  always_comb begin
    mem_req       = '0;
    mem_req.waddr = {cur_q_r, tail_r[cur_q_r]};
    mem_req.wdata = {due_r, tag_r, bus_r, instr_r, class_r};
    mem_req.raddr = {cur_q_r, head_r[cur_q_r]};
    unique case (state_r)
      S_LWR: begin
        mem_req.we = ~fill_r[cur_q_r][FW-1];
      end
      S_PRD: begin
        mem_req.re = (fill_r[cur_q_r] != '0);
      end
      S_HRD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = {scan_r, head_r[scan_r]};
      end
      default: begin
      end
    endcase
  end

  tcd_entry_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cfg_queues_r  <= 5'd1;
      cfg_total_r   <= 16'd0;
      cfg_timeout_r <= 16'd1000;
      time_r        <= '0;
      running_r     <= 1'b0;
      awaiting_r    <= 1'b0;
      wait_r        <= '0;
      done_r        <= '0;
      scan_r        <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < tcd_pkg::NUM_QUEUES; i++) begin
        owner_r[i] <= tcd_pkg::FREE_OWNER;
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        fill_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tcd_pkg::CFG_QUEUES:  cfg_queues_r  <= cfg_data[4:0];
          tcd_pkg::CFG_TOTAL:   cfg_total_r   <= cfg_data;
          tcd_pkg::CFG_TIMEOUT: cfg_timeout_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= tcd_pkg::func_t'(in_func);
            addr_r  <= in_dev_address;
            due_r   <= in_due_time;
            class_r <= in_cmd_class;
            instr_r <= in_cmd_instruction;
            bus_r   <= in_bus_select;
            tag_r   <= in_param_tag;
            reply_r <= in_reply_instruction;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_kind_r <= tcd_pkg::KIND_ACK;
          res_head_r <= 1'b0;
          state_r    <= S_DONE;
          unique case (func_r)
            tcd_pkg::FUNC_LOAD: begin
              cnt_r        <= '0;
              free_found_r <= 1'b0;
              state_r      <= S_LSRCH;
            end
            tcd_pkg::FUNC_START: begin
              running_r  <= 1'b1;
              time_r     <= '0;
              done_r     <= '0;
              scan_r     <= '0;
              awaiting_r <= 1'b0;
              wait_r     <= '0;
            end
            tcd_pkg::FUNC_STOP: begin
              running_r  <= 1'b0;
              awaiting_r <= 1'b0;
              wait_r     <= '0;
            end
            tcd_pkg::FUNC_TICK: begin
              if (time_r == 32'hFFFF_FFFF) begin
                running_r  <= 1'b0;
                awaiting_r <= 1'b0;
                wait_r     <= '0;
              end
              time_r <= time_r + 32'd1;
            end
            tcd_pkg::FUNC_POLL: begin
              if (!running_r) begin
                // nothing to do
              end else if (awaiting_r) begin
                wait_r <= wait_inc;
                if (wait_inc >= lim) begin
                  state_r <= S_HRD;
                end
              end else if (done_r >= cfg_total_r) begin
                running_r  <= 1'b0;
                awaiting_r <= 1'b0;
                wait_r     <= '0;
              end else begin
                if ({1'b0, scan_r} >= nq) begin
                  scan_r  <= '0;
                  cur_q_r <= '0;
                end else begin
                  cur_q_r <= scan_r;
                end
                cnt_r   <= '0;
                state_r <= S_PRD;
              end
            end
            tcd_pkg::FUNC_REPLY: begin
              if (!awaiting_r || fill_r[scan_r] == '0) begin
                awaiting_r <= 1'b0;
              end else begin
                state_r <= S_HRD;
              end
            end
            default: begin
            end
          endcase
        end

        // one owner compare per cycle: exact match wins, else first free queue
        S_LSRCH: begin
          if (owner_r[cnt_r] == addr_r) begin
            cur_q_r <= cnt_r;
            state_r <= S_LWR;
          end else begin
            if (owner_r[cnt_r] == tcd_pkg::FREE_OWNER && !free_found_r) begin
              free_found_r <= 1'b1;
              free_q_r     <= cnt_r;
            end
            if (last_cnt) begin
              if (free_found_r) begin
                cur_q_r <= free_q_r;
                state_r <= S_LWR;
              end else if (owner_r[cnt_r] == tcd_pkg::FREE_OWNER) begin
                cur_q_r <= cnt_r;
                state_r <= S_LWR;
              end else begin
                res_kind_r <= tcd_pkg::KIND_NOFREE;
                state_r    <= S_DONE;
              end
            end else begin
              cnt_r <= cnt_r + QW'(1);
            end
          end
        end

        S_LWR: begin
          if (fill_r[cur_q_r][FW-1]) begin
            res_kind_r <= tcd_pkg::KIND_FULL;
          end else begin
            owner_r[cur_q_r] <= addr_r;
            tail_r[cur_q_r]  <= tail_r[cur_q_r] + SW'(1);
            fill_r[cur_q_r]  <= fill_r[cur_q_r] + FW'(1);
          end
          state_r <= S_DONE;
        end

        S_PRD: begin
          if (fill_r[cur_q_r] != '0) begin
            state_r <= S_PCMP;
          end else if (last_cnt) begin
            state_r <= S_DONE;
          end else begin
            cnt_r   <= cnt_r + QW'(1);
            cur_q_r <= cur_next;
          end
        end

        S_PCMP: begin
          if (rd_due <= time_r) begin
            scan_r     <= cur_q_r;
            awaiting_r <= 1'b1;
            wait_r     <= '0;
            res_kind_r <= tcd_pkg::KIND_DISPATCH;
            res_head_r <= 1'b1;
            res_addr_r <= owner_r[cur_q_r];
            state_r    <= S_DONE;
          end else if (last_cnt) begin
            state_r <= S_DONE;
          end else begin
            cnt_r   <= cnt_r + QW'(1);
            cur_q_r <= cur_next;
            state_r <= S_PRD;
          end
        end

        S_HRD: begin
          state_r <= S_HUSE;
        end

        S_HUSE: begin
          res_head_r <= 1'b1;
          res_addr_r <= owner_r[scan_r];
          awaiting_r <= 1'b0;
          wait_r     <= '0;
          scan_r     <= scan_next;
          if (func_r == tcd_pkg::FUNC_POLL) begin
            res_kind_r <= tcd_pkg::KIND_TIMEOUT;
          end else if (rd_info[15:8] != reply_r) begin
            res_kind_r <= tcd_pkg::KIND_MISMATCH;
          end else begin
            res_kind_r     <= tcd_pkg::KIND_CONFIRMED;
            head_r[scan_r] <= head_r[scan_r] + SW'(1);
            fill_r[scan_r] <= fill_r[scan_r] - FW'(1);
            done_r         <= done_inc;
            if (done_inc >= cfg_total_r) begin
              running_r <= 1'b0;
            end
          end
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_result_kind     <= res_kind_r;
            out_address         <= res_head_r ? res_addr_r : 8'd0;
            out_class           <= res_head_r ? rd_info[7:0] : 8'd0;
            out_instruction     <= res_head_r ? rd_info[15:8] : 8'd0;
            out_bus             <= res_head_r ? rd_info[16] : 1'b0;
            out_tag             <= res_head_r ? rd_info[32:17] : 16'd0;
            out_run_active      <= running_r;
            out_confirmed_count <= done_r;
            state_r             <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wait_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> running_r)
    else $error("reply wait outside a run");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[scan_r] <= FW'(tcd_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && state_r == S_EXEC))
    else $error("word not taken into the sequencer");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_LWR && !fill_r[cur_q_r][FW-1]))
    else $error("entry write outside a load");
`endif

endmodule
